// ===== rtl/ipv6_text_address_parser_defines.svh =====
// ----------------------------------------------------------------------------
// IPv6 text address parser - assertion macros
// Overlapping-implication and next-cycle property wrappers; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef IPV6_TEXT_ADDRESS_PARSER_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define IPV6TAP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IPV6TAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IPV6TAP_ASSERT_IMP(label, clk, rst, ante, cons)
`define IPV6TAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ipv6tap_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv6 text address parser - package
// Sizes, character codes, parse state type and hex digit decoder.
// ----------------------------------------------------------------------------
package ipv6tap_pkg;

  localparam int GROUP_COUNT = 8;
  localparam int OUT_GROUPS  = 8;
  localparam int GROUP_W     = 16;
  localparam int CHAR_W      = 8;
  localparam int GIDX_W      = $clog2(GROUP_COUNT);
  localparam int GCNT_W      = $clog2(GROUP_COUNT + 1);
  localparam int DIGIT_W     = 3;
  localparam int MAX_DIGITS  = 4;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;

  typedef struct packed {
    logic [GROUP_W-1:0] acc;
    logic [DIGIT_W-1:0] digits;
    logic [GCNT_W-1:0]  done;
    logic [GCNT_W-1:0]  gap_pos;
    logic               gap_seen;
    logic               prev_colon;
    logic               error;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t   r;
    logic [CHAR_W-1:0] d;
    r = '0;
    d = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
      r.valid = 1'b1;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = c - CHAR_LA + 8'd10;
      r.valid = 1'b1;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA + 8'd10;
      r.valid = 1'b1;
    end
    r.nibble = d[3:0];
    return r;
  endfunction

endpackage

// ===== rtl/ipv6tap_if.sv =====
// ----------------------------------------------------------------------------
// IPv6 text address parser - channel interfaces
// Character channel in, address channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipv6tap_text_if;
  logic                            valid;
  logic                            ready;
  logic [ipv6tap_pkg::CHAR_W-1:0]  text_char;
  logic                            last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface ipv6tap_addr_if;
  logic                             valid;
  logic                             ready;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_0;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_1;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_2;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_3;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_4;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_5;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_6;
  logic [ipv6tap_pkg::GROUP_W-1:0]  group_7;
  logic                             malformed;

  modport source (output valid, output group_0, output group_1, output group_2,
                  output group_3, output group_4, output group_5, output group_6,
                  output group_7, output malformed, input ready);
  modport sink   (input valid, input group_0, input group_1, input group_2,
                  input group_3, input group_4, input group_5, input group_6,
                  input group_7, input malformed, output ready);
endinterface

// ===== rtl/ipv6_text_address_parser.sv =====
// ----------------------------------------------------------------------------
// IPv6 text address parser
// Takes one character per beat and returns the eight address groups.
// ----------------------------------------------------------------------------
// One character is taken per clock while text.ready is high. Each character
// updates the parse state (group being built, finished groups, double-colon
// position). The beat flagged last_char copies the state into a frame
// register and the parse state clears, so the next address may start in the
// following cycle. Once the frame register holds a frame and the output
// register can take it, the frame is closed, the double-colon gap is expanded
// with a group shifter and the result lands in the output register that drives
// addr.valid. The output register and the frame register form a two-deep
// path, so characters keep flowing while a result waits; text.ready drops only
// when both are held. Malformed text gives malformed = 1 with all groups zero.
// ----------------------------------------------------------------------------
`include "ipv6_text_address_parser_defines.svh"

module ipv6_text_address_parser (
  input  logic           clk,
  input  logic           rst,
  ipv6tap_text_if.sink   text,
  ipv6tap_addr_if.source addr
);

  localparam int GC  = ipv6tap_pkg::GROUP_COUNT;
  localparam int GW  = ipv6tap_pkg::GROUP_W;
  localparam int CW  = ipv6tap_pkg::GCNT_W;
  localparam int IW  = ipv6tap_pkg::GIDX_W;
  localparam int DW  = ipv6tap_pkg::DIGIT_W;

  ipv6tap_pkg::parse_state_t state, state_next;
  logic [GW-1:0] group_store [GC];
  logic [GW-1:0] store_next  [GC];

  ipv6tap_pkg::parse_state_t frame;
  logic [GW-1:0] frame_store [GC];
  logic          frame_valid;

  logic [GW-1:0] out_group [ipv6tap_pkg::OUT_GROUPS];
  logic [GW-1:0] out_group_next [ipv6tap_pkg::OUT_GROUPS];
  logic          out_malformed;
  logic          out_valid;

  logic text_fire, out_load, frame_free;
  ipv6tap_pkg::hex_digit_t hex;

  assign out_load   = frame_valid && (!out_valid || addr.ready);
  assign frame_free = !frame_valid || out_load;
  assign text.ready = frame_free;
  assign text_fire  = text.valid && frame_free;

  // character step
  always_comb begin
    hex        = ipv6tap_pkg::hex_decode(text.text_char);
    state_next = state;
    store_next = group_store;
    if (!state.error) begin
      if (hex.valid) begin
        if (state.digits == DW'(ipv6tap_pkg::MAX_DIGITS) ||
            (state.prev_colon && state.done == '0 && !state.gap_seen)) begin
          state_next.error = 1'b1;
        end else begin
          state_next.acc        = {state.acc[GW-5:0], hex.nibble};
          state_next.digits     = state.digits + DW'(1);
          state_next.prev_colon = 1'b0;
        end
      end else if (text.text_char == ipv6tap_pkg::CHAR_COLON) begin
        state_next.prev_colon = 1'b1;
        if (state.digits != '0) begin
          if (state.done >= CW'(GC)) begin
            state_next.error = 1'b1;
          end else begin
            store_next[state.done[IW-1:0]] = state.acc;
            state_next.done   = state.done + CW'(1);
            state_next.acc    = '0;
            state_next.digits = '0;
          end
        end else if (state.prev_colon) begin
          if (state.gap_seen) begin
            state_next.error = 1'b1;
          end else begin
            state_next.gap_seen = 1'b1;
            state_next.gap_pos  = state.done;
          end
        end
      end else begin
        state_next.error = 1'b1;
      end
    end
  end

  // closing and gap expansion
  logic [GW-1:0]    fin_store [GC];
  logic [CW-1:0]    fin_done;
  logic [CW-1:0]    zeros;
  logic             fin_err;
  logic [GC*GW-1:0] fin_flat;
  logic [GC*GW-1:0] fin_shift;
  logic [GW-1:0]    full [GC];

  always_comb begin
    fin_store = frame_store;
    fin_done  = frame.done;
    fin_err   = frame.error;
    if (!fin_err) begin
      if (frame.digits != '0) begin
        if (frame.done >= CW'(GC)) begin
          fin_err = 1'b1;
        end else begin
          fin_store[frame.done[IW-1:0]] = frame.acc;
          fin_done = frame.done + CW'(1);
        end
      end else if (frame.prev_colon &&
                   !(frame.gap_seen && frame.gap_pos == frame.done)) begin
        fin_err = 1'b1;
      end
    end
    if (!fin_err) begin
      if (frame.gap_seen ? (fin_done >= CW'(GC)) : (fin_done != CW'(GC))) begin
        fin_err = 1'b1;
      end
    end
    zeros = CW'(GC) - fin_done;
    for (int i = 0; i < GC; i++) begin
      fin_flat[i*GW +: GW] = fin_store[i];
    end
    fin_shift = fin_flat << (zeros * GW);
    for (int i = 0; i < GC; i++) begin
      if (fin_err) begin
        full[i] = '0;
      end else if (!frame.gap_seen || (CW+1)'(i) < {1'b0, frame.gap_pos}) begin
        full[i] = fin_flat[i*GW +: GW];
      end else if ((CW+1)'(i) >= ({1'b0, frame.gap_pos} + {1'b0, zeros})) begin
        full[i] = fin_shift[i*GW +: GW];
      end else begin
        full[i] = '0;
      end
    end
    for (int i = 0; i < ipv6tap_pkg::OUT_GROUPS; i++) begin
      out_group_next[i] = '0;
      if (i < GC) begin
        out_group_next[i] = full[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      frame_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (text_fire) begin
        state <= text.last_char ? '0 : state_next;
      end
      if (text_fire && text.last_char) begin
        frame_valid <= 1'b1;
      end else if (out_load) begin
        frame_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (addr.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_fire) begin
      group_store <= store_next;
    end
    if (text_fire && text.last_char) begin
      frame       <= state_next;
      frame_store <= store_next;
    end
    if (out_load) begin
      out_group     <= out_group_next;
      out_malformed <= fin_err;
    end
  end

  assign addr.valid     = out_valid;
  assign addr.malformed = out_malformed;
  assign addr.group_0   = out_group[0];
  assign addr.group_1   = out_group[1];
  assign addr.group_2   = out_group[2];
  assign addr.group_3   = out_group[3];
  assign addr.group_4   = out_group[4];
  assign addr.group_5   = out_group[5];
  assign addr.group_6   = out_group[6];
  assign addr.group_7   = out_group[7];

  `IPV6TAP_ASSERT_NEXT(a_last_opens_frame, clk, rst, text_fire && text.last_char, frame_valid)
  `IPV6TAP_ASSERT_NEXT(a_last_clears_state, clk, rst, text_fire && text.last_char, state == '0)
  `IPV6TAP_ASSERT_NEXT(a_frame_holds, clk, rst, frame_valid && !out_load, frame_valid && $stable(frame))
  `IPV6TAP_ASSERT_IMP(a_done_bound, clk, rst, 1'b1, state.done <= CW'(GC))
  `IPV6TAP_ASSERT_IMP(a_bad_is_zero, clk, rst, out_valid && out_malformed, (addr.group_0 | addr.group_1 | addr.group_2 | addr.group_3 | addr.group_4 | addr.group_5 | addr.group_6 | addr.group_7) == '0)

endmodule
